// ===== sv/ped_pkg.sv =====
// Shared types, character constants and hex helpers for the percent escape decoder.
// Used by ped_front, ped_queue, ped_back and percent_escape_decoder; depends on nothing.
package ped_pkg;

   // Input beat: one raw byte of the encoded string and its end flag.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   // Result beat: one decoded byte or a bare end marker.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_last;
      logic       string_done;
   } rsp_type;

   // Classified work for one accepted input item: up to two bytes to deliver.
   // A count of zero with done set stands for a bare end marker.
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       done;
   } rec_type;

   // Escape phases.
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_PCT   = 2'd1;
   localparam logic [1:0] PHASE_DIGIT = 2'd2;

   // Characters of interest.
   localparam logic [7:0] CHAR_PCT = 8'h25;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   // Decoupling queue geometry (depth must be a power of two).
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // True for 0-9, a-f and A-F.
   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   // Nibble value of a hex digit character; zero for anything else.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         v = c - 8'h30;
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         v = c - 8'h57;
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

endpackage

// ===== sv/ped_front.sv =====
// Front end of the percent escape decoder: accepts input beats, tracks the escape
// state and classifies each item into a record of up to two bytes. Depends on ped_pkg.
module ped_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  ped_pkg::req_type req_data,
   input  logic             queue_full,
   output logic             rec_push,
   output ped_pkg::rec_type rec_data
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       term_ff, term_in;

   logic       accept;
   logic [7:0] b;
   logic       b_hex;
   logic       a_vld, b_vld, f_vld;
   logic [7:0] a_val, b_val, f_val;
   logic [1:0] mid_phase;
   logic [7:0] mid_held;
   logic       mid_term;

   assign accept = req_push && !queue_full;
   assign b      = req_data.in_byte;
   assign b_hex  = ped_pkg::is_hex(b);

   // Feed the byte through the escape state; up to two emits in order (first, second).
   always_comb begin
      a_vld     = 1'b0;
      a_val     = held_ff;
      b_vld     = 1'b0;
      b_val     = b;
      mid_phase = phase_ff;
      mid_held  = held_ff;
      mid_term  = term_ff;
      if (!term_ff) begin
         if (b == ped_pkg::CHAR_NUL) begin
            // The terminator flushes a held digit and drops a held '%'.
            a_vld     = (phase_ff == ped_pkg::PHASE_DIGIT);
            mid_phase = ped_pkg::PHASE_IDLE;
            mid_held  = 8'h00;
            mid_term  = 1'b1;
         end else begin
            case (phase_ff)
               ped_pkg::PHASE_PCT: begin
                  if (b_hex) begin
                     mid_held  = b;
                     mid_phase = ped_pkg::PHASE_DIGIT;
                  end else begin
                     b_vld     = (b != ped_pkg::CHAR_PCT);
                     mid_phase = (b == ped_pkg::CHAR_PCT) ? ped_pkg::PHASE_PCT
                                                          : ped_pkg::PHASE_IDLE;
                  end
               end
               ped_pkg::PHASE_DIGIT: begin
                  a_vld    = 1'b1;
                  mid_held = 8'h00;
                  if (b_hex) begin
                     a_val     = {ped_pkg::hex_value(held_ff), ped_pkg::hex_value(b)};
                     mid_phase = ped_pkg::PHASE_IDLE;
                  end else begin
                     b_vld     = (b != ped_pkg::CHAR_PCT);
                     mid_phase = (b == ped_pkg::CHAR_PCT) ? ped_pkg::PHASE_PCT
                                                          : ped_pkg::PHASE_IDLE;
                  end
               end
               default: begin
                  b_vld     = (b != ped_pkg::CHAR_PCT);
                  mid_phase = (b == ped_pkg::CHAR_PCT) ? ped_pkg::PHASE_PCT
                                                       : ped_pkg::PHASE_IDLE;
               end
            endcase
         end
      end
   end

   // End flag flushes a digit still held after the byte; it only arises with no other emit.
   assign f_vld = req_data.end_of_string && (mid_phase == ped_pkg::PHASE_DIGIT);
   assign f_val = mid_held;

   // Compact the emits into the record and decide whether it goes to the queue.
   always_comb begin
      rec_data.count = {1'b0, a_vld} + {1'b0, b_vld} + {1'b0, f_vld};
      rec_data.byte0 = a_vld ? a_val : (b_vld ? b_val : f_val);
      rec_data.byte1 = a_vld ? (b_vld ? b_val : f_val) : f_val;
      rec_data.done  = req_data.end_of_string;
      rec_push       = accept && ((rec_data.count != 2'd0) || req_data.end_of_string);
   end

   // Next escape state; the end flag returns everything to its reset values.
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      term_in  = term_ff;
      if (accept) begin
         if (req_data.end_of_string) begin
            phase_in = ped_pkg::PHASE_IDLE;
            held_in  = 8'h00;
            term_in  = 1'b0;
         end else begin
            phase_in = mid_phase;
            held_in  = mid_held;
            term_in  = mid_term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ped_pkg::PHASE_IDLE;
         held_ff  <= 8'h00;
         term_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         term_ff  <= term_in;
      end
   end

endmodule

// ===== sv/ped_queue.sv =====
// Short record queue that decouples the front end from the back end.
// Depends on ped_pkg for the record type and queue geometry.
module ped_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ped_pkg::rec_type push_data,
   input  logic             pop,
   output ped_pkg::rec_type head_data,
   output logic             empty,
   output logic             full
);

   ped_pkg::rec_type                   slot_ff [ped_pkg::QUEUE_DEPTH];
   logic [ped_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ped_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ped_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                               do_push, do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == ped_pkg::QUEUE_CNT_W'(ped_pkg::QUEUE_DEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/ped_back.sv =====
// Back end of the percent escape decoder: splits queued records into result beats
// and holds them in the output register. Depends on ped_pkg.
module ped_back (
   input  logic             clock,
   input  logic             reset,
   input  ped_pkg::rec_type head_data,
   input  logic             queue_empty,
   output logic             queue_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output ped_pkg::rsp_type rsp_data
);

   logic             out_valid_ff, out_valid_in;
   ped_pkg::rsp_type out_data_ff, out_data_in;
   logic             idx_ff, idx_in;
   logic             load;
   logic             is_last;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign load      = !queue_empty && (!out_valid_ff || rsp_pop);

   // Build the beat for the current byte of the head record.
   always_comb begin
      is_last                 = (head_data.count != 2'd2) || idx_ff;
      out_data_in.out_byte    = idx_ff ? head_data.byte1 : head_data.byte0;
      out_data_in.has_byte    = (head_data.count != 2'd0);
      out_data_in.run_last    = is_last;
      out_data_in.string_done = is_last && head_data.done;
      queue_pop               = load && is_last;
   end

   // Output register and byte index control.
   always_comb begin
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = !is_last;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// ===== sv/percent_escape_decoder.sv =====
// Top level of the percent escape decoder: front end, record queue and back end.
// Depends on ped_pkg, ped_front, ped_queue and ped_back.
//
// Usage: raw bytes enter as beats on the req_ queue port (push while full is low);
// decoded bytes leave on the rsp_ queue port (data valid while empty is low, pop
// takes it). A '%' with two hex digits becomes one byte, a broken escape drops
// only the '%', and a zero byte ends the string; end_of_string closes it and
// returns the decoder to its reset state for the next string.
// Each input item yields zero, one or two result beats; run_last marks the last
// of them and string_done the final beat of a string. An end flag on an item
// with no data gives one bare end marker (has_byte low).
// Path: an accepted item is written into the record queue, then loaded into the
// output register, from which its result beats are visible.
// Throughput: one item per cycle while rsp_pop keeps up, limited by the single output
// register which delivers one beat per cycle, so items that yield two bytes slow it.
// Stalls: when pop stays low, the output register holds one beat and the
// two-entry record queue fills behind it; full then stays high until pop
// resumes, and no beat is lost. Reset empties the queue and the output register
// and clears the escape state.
module percent_escape_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  ped_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output ped_pkg::rsp_type rsp_data
);

   logic             rec_push;
   ped_pkg::rec_type rec_data;
   ped_pkg::rec_type head_data;
   logic             queue_empty;
   logic             queue_pop;

   ped_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (req_full),
      .rec_push   (rec_push),
      .rec_data   (rec_data)
   );

   ped_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_data),
      .pop       (queue_pop),
      .head_data (head_data),
      .empty     (queue_empty),
      .full      (req_full)
   );

   ped_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_data   (head_data),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   // The end of a string always closes the run of its item.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.string_done) |-> rsp_data.run_last)
      else $error("string_done without run_last");

   // A beat without data is only ever the bare end marker.
   a_bare_is_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.has_byte) |-> (rsp_data.string_done && rsp_data.run_last))
      else $error("bare beat that is not an end marker");

   // The second byte of a two-byte item follows its first without a gap.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.run_last) |=> !rsp_empty)
      else $error("run broken after a non-final beat");
`endif

endmodule
